FILE: rtl/roman_numeral_encoder_core_defines.svh
// Assertion macros for the Roman numeral encoder.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef ROMAN_NUMERAL_ENCODER_CORE_DEFINES_SVH
`define ROMAN_NUMERAL_ENCODER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RNE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RNE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RNE_ASSERT_SAME(lbl, ante, cons)
`define RNE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/rne_pkg.sv
// Types, constants and symbol tables of the Roman numeral encoder.
// Depends on nothing.
package rne_pkg;

    typedef logic [3:0] digit_t;
    typedef logic [1:0] place_t;
    typedef logic [1:0] step_t;

    typedef struct packed {
        logic              err;
        digit_t [3:0]      digits;
    } item_t;

    typedef enum logic [1:0] {
        POS_ONE,
        POS_FIVE,
        POS_TEN
    } pos_t;

    localparam logic [11:0] VALUE_LIMIT = 12'd4000;

    localparam logic [7:0] CHAR_ERROR = 8'h00;
    localparam logic [7:0] CHAR_I     = 8'h49;
    localparam logic [7:0] CHAR_V     = 8'h56;
    localparam logic [7:0] CHAR_X     = 8'h58;
    localparam logic [7:0] CHAR_L     = 8'h4C;
    localparam logic [7:0] CHAR_C     = 8'h43;
    localparam logic [7:0] CHAR_D     = 8'h44;
    localparam logic [7:0] CHAR_M     = 8'h4D;

    function automatic logic [2:0] pat_len(digit_t d);
        logic [2:0] len;
        unique case (d)
            4'd1, 4'd5:                len = 3'd1;
            4'd2, 4'd4, 4'd6, 4'd9:    len = 3'd2;
            4'd3, 4'd7:                len = 3'd3;
            4'd8:                      len = 3'd4;
            default:                   len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic pos_t pat_pos(digit_t d, step_t k);
        pos_t pos;
        unique case (d)
            4'd4:                      pos = (k == 2'd1) ? POS_FIVE : POS_ONE;
            4'd5, 4'd6, 4'd7, 4'd8:    pos = (k == 2'd0) ? POS_FIVE : POS_ONE;
            4'd9:                      pos = (k == 2'd1) ? POS_TEN : POS_ONE;
            default:                   pos = POS_ONE;
        endcase
        return pos;
    endfunction

    function automatic logic [7:0] symbol(place_t p, pos_t s);
        logic [7:0] ch;
        unique case (p)
            2'd0:
            begin
                ch = (s == POS_ONE) ? CHAR_I : ((s == POS_FIVE) ? CHAR_V : CHAR_X);
            end
            2'd1:
            begin
                ch = (s == POS_ONE) ? CHAR_X : ((s == POS_FIVE) ? CHAR_L : CHAR_C);
            end
            2'd2:
            begin
                ch = (s == POS_ONE) ? CHAR_C : ((s == POS_FIVE) ? CHAR_D : CHAR_M);
            end
            default:
            begin
                ch = CHAR_M;
            end
        endcase
        return ch;
    endfunction

endpackage

FILE: rtl/rne_front.sv
// Front end: accepts values, checks the range and splits them into decimal digits.
// Depends on rne_pkg.
module rne_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic [11:0]     value,
    output logic            full,
    output logic            out_valid,
    output rne_pkg::item_t  out_item,
    input  logic            out_ready
);

    logic            s1_valid_reg;
    logic            s1_valid_next;
    logic            s1_err_reg;
    logic [1:0]      s1_th_reg;
    logic [9:0]      s1_rem_reg;
    logic            s2_valid_reg;
    logic            s2_valid_next;
    rne_pkg::item_t  s2_item_reg;

    logic            s1_move;
    logic            s2_move;
    logic            err_c;
    logic [1:0]      th_c;
    logic [9:0]      rem_c;
    rne_pkg::item_t  item_c;

    assign s2_move = !s2_valid_reg || out_ready;
    assign s1_move = !s1_valid_reg || s2_move;
    assign full = !s1_move;
    assign out_valid = s2_valid_reg;
    assign out_item = s2_item_reg;

    assign s1_valid_next = s1_move ? push : s1_valid_reg;
    assign s2_valid_next = s2_move ? s1_valid_reg : s2_valid_reg;

    always_comb
    begin
        err_c = (value == 12'd0) || (value >= rne_pkg::VALUE_LIMIT);
        priority if (value >= 12'd3000)
        begin
            th_c = 2'd3;
            rem_c = 10'(value - 12'd3000);
        end
        else if (value >= 12'd2000)
        begin
            th_c = 2'd2;
            rem_c = 10'(value - 12'd2000);
        end
        else if (value >= 12'd1000)
        begin
            th_c = 2'd1;
            rem_c = 10'(value - 12'd1000);
        end
        else
        begin
            th_c = 2'd0;
            rem_c = value[9:0];
        end
    end

    always_comb
    begin
        logic [3:0] hun;
        logic [3:0] ten;
        logic [6:0] rem2;
        logic [3:0] rem3;
        hun = 4'd0;
        ten = 4'd0;
        rem2 = s1_rem_reg[6:0];
        rem3 = 4'd0;
        for (int i = 1; i <= 9; i++)
        begin
            if (s1_rem_reg >= 10'(i * 100))
            begin
                hun = 4'(i);
                rem2 = 7'(s1_rem_reg - 10'(i * 100));
            end
        end
        rem3 = rem2[3:0];
        for (int j = 1; j <= 9; j++)
        begin
            if (rem2 >= 7'(j * 10))
            begin
                ten = 4'(j);
                rem3 = 4'(rem2 - 7'(j * 10));
            end
        end
        item_c.err = s1_err_reg;
        item_c.digits[3] = {2'b00, s1_th_reg};
        item_c.digits[2] = hun;
        item_c.digits[1] = ten;
        item_c.digits[0] = rem3;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s1_err_reg <= err_c;
            s1_th_reg <= th_c;
            s1_rem_reg <= rem_c;
        end
        if (s2_move)
        begin
            s2_item_reg <= item_c;
        end
    end

endmodule

FILE: rtl/rne_queue.sv
// Small queue of classified items between the front end and the back end.
// Depends on rne_pkg.
module rne_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rne_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output rne_pkg::item_t  head_item,
    output logic            empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    rne_pkg::item_t    store_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign head_item = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/rne_back.sv
// Back end: walks an item's digits; emits a character per cycle unless stalled.
// Depends on rne_pkg.
module rne_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  rne_pkg::item_t  q_item,
    output logic            q_pop,
    output logic [7:0]      char_code,
    output logic            last,
    output logic            range_error,
    output logic            empty,
    input  logic            pop
);

    logic                cur_valid_reg;
    logic                cur_valid_next;
    rne_pkg::item_t      cur_item_reg;
    rne_pkg::item_t      cur_item_next;
    rne_pkg::place_t     place_reg;
    rne_pkg::place_t     place_next;
    rne_pkg::step_t      step_reg;
    rne_pkg::step_t      step_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [7:0]          out_char_reg;
    logic                out_last_reg;
    logic                out_err_reg;

    logic                out_free;
    logic                emit;
    logic                load;
    logic                step_last;
    logic                below_found;
    rne_pkg::place_t     below_place;
    rne_pkg::place_t     start_place;
    rne_pkg::digit_t     cur_digit;
    logic                done;
    logic [7:0]          char_c;

    assign out_free = !out_valid_reg || pop;
    assign emit = cur_valid_reg && out_free;
    assign cur_digit = cur_item_reg.digits[place_reg];
    assign step_last = ({1'b0, step_reg} + 3'd1) >= rne_pkg::pat_len(cur_digit);
    assign done = cur_item_reg.err || (step_last && !below_found);
    assign load = (!cur_valid_reg || (emit && done)) && !q_empty;
    assign q_pop = load;
    assign char_c = cur_item_reg.err ? rne_pkg::CHAR_ERROR
                  : rne_pkg::symbol(place_reg, rne_pkg::pat_pos(cur_digit, step_reg));

    assign empty = !out_valid_reg;
    assign char_code = out_char_reg;
    assign last = out_last_reg;
    assign range_error = out_err_reg;

    always_comb
    begin
        below_found = 1'b0;
        below_place = 2'd0;
        for (int i = 0; i < 4; i++)
        begin
            if ((2'(i) < place_reg) && (cur_item_reg.digits[i] != 4'd0))
            begin
                below_found = 1'b1;
                below_place = 2'(i);
            end
        end
    end

    always_comb
    begin
        start_place = 2'd0;
        for (int i = 0; i < 4; i++)
        begin
            if (q_item.digits[i] != 4'd0)
            begin
                start_place = 2'(i);
            end
        end
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_item_next = cur_item_reg;
        place_next = place_reg;
        step_next = step_reg;
        if (load)
        begin
            cur_valid_next = 1'b1;
            cur_item_next = q_item;
            place_next = start_place;
            step_next = 2'd0;
        end
        else if (emit && done)
        begin
            cur_valid_next = 1'b0;
        end
        else if (emit)
        begin
            if (step_last)
            begin
                place_next = below_place;
                step_next = 2'd0;
            end
            else
            begin
                step_next = step_reg + 2'd1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_item_reg <= cur_item_next;
        place_reg <= place_next;
        step_reg <= step_next;
        if (emit)
        begin
            out_char_reg <= char_c;
            out_last_reg <= done;
            out_err_reg <= cur_item_reg.err;
        end
    end

endmodule

FILE: rtl/roman_numeral_encoder_core.sv
// Top level of the Roman numeral encoder: front end, item queue and back end.
// Depends on rne_pkg, rne_front, rne_queue, rne_back and the defines header.
//
// Channel   Handshake          Payload
// input     push / full        value[11:0]
// result    empty / pop        char_code[7:0], last, range_error
//
// Each value yields one to fifteen characters (one for an out-of-range value); the
// back end emits one character per cycle while the result side pops. The first
// character passes front s1 and s2, the queue and the back end's current-item and
// output registers. Reset clears all valid flags and queue pointers. A stalled
// result side fills the queue and then raises full; values keep flowing meanwhile.
`include "roman_numeral_encoder_core_defines.svh"

module roman_numeral_encoder_core
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [11:0]  value,
    output logic         full,
    output logic [7:0]   char_code,
    output logic         last,
    output logic         range_error,
    output logic         empty,
    input  logic         pop
);

    logic            f_valid;
    rne_pkg::item_t  f_item;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;
    rne_pkg::item_t  q_item;

    rne_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .value     (value),
        .full      (full),
        .out_valid (f_valid),
        .out_item  (f_item),
        .out_ready (!q_full)
    );

    rne_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_valid),
        .push_item (f_item),
        .full      (q_full),
        .pop       (q_pop),
        .head_item (q_item),
        .empty     (q_empty)
    );

    rne_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .char_code   (char_code),
        .last        (last),
        .range_error (range_error),
        .empty       (empty),
        .pop         (pop)
    );

    `RNE_ASSERT_SAME(a_error_form, !empty && range_error, char_code == 8'd0 && last)
    `RNE_ASSERT_SAME(a_valid_char, !empty && !range_error, char_code != 8'd0)
    `RNE_ASSERT_SAME(a_no_pop_empty, q_pop, !q_empty)
    `RNE_ASSERT_NEXT(a_held_push, f_valid && q_full, f_valid)

endmodule

FILE: tb/rne_numeral_checker.sv
// Watches both channels of the Roman numeral encoder, spells each accepted value
// as the characters it must produce and compares every popped character with them.
// Depends on rne_pkg for the character codes.
module rne_numeral_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [11:0] value,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  char_code,
    input  logic        last,
    input  logic        range_error,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       err;
    } roman_char_t;

    roman_char_t expected_chars[$];
    int          reported;

    function automatic void spell_numeral(logic [11:0] v);
        logic [7:0]  run[15];
        int          n;
        int          place;
        int          d;
        int          k;
        int          scale;
        logic [7:0]  one;
        logic [7:0]  five;
        logic [7:0]  ten;
        roman_char_t item;

        n = 0;
        if (v == 12'd0 || v >= rne_pkg::VALUE_LIMIT)
        begin
            item.code = rne_pkg::CHAR_ERROR;
            item.last = 1'b1;
            item.err  = 1'b1;
            expected_chars.push_back(item);
            return;
        end
        scale = 1000;
        for (place = 3; place >= 0; place--)
        begin
            d = (int'(v) / scale) % 10;
            scale = scale / 10;
            case (place)
                3:
                begin
                    one = rne_pkg::CHAR_M;
                    five = rne_pkg::CHAR_M;
                    ten = rne_pkg::CHAR_M;
                end
                2:
                begin
                    one = rne_pkg::CHAR_C;
                    five = rne_pkg::CHAR_D;
                    ten = rne_pkg::CHAR_M;
                end
                1:
                begin
                    one = rne_pkg::CHAR_X;
                    five = rne_pkg::CHAR_L;
                    ten = rne_pkg::CHAR_C;
                end
                default:
                begin
                    one = rne_pkg::CHAR_I;
                    five = rne_pkg::CHAR_V;
                    ten = rne_pkg::CHAR_X;
                end
            endcase
            if (d == 9)
            begin
                run[n] = one;
                run[n + 1] = ten;
                n = n + 2;
            end
            else if (d == 4)
            begin
                run[n] = one;
                run[n + 1] = five;
                n = n + 2;
            end
            else
            begin
                if (d >= 5)
                begin
                    run[n] = five;
                    n = n + 1;
                end
                for (k = 0; k < d % 5; k++)
                begin
                    run[n] = one;
                    n = n + 1;
                end
            end
        end
        for (k = 0; k < n; k++)
        begin
            item.code = run[k];
            item.last = (k == n - 1);
            item.err  = 1'b0;
            expected_chars.push_back(item);
        end
    endfunction

    always @(posedge clk)
    begin
        roman_char_t want;
        if (!rst_n)
        begin
            expected_chars.delete();
            fail_count = 0;
            pending_count = 0;
            reported = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_chars.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    if (reported < 10)
                    begin
                        $display("unexpected transaction: %h %b %b",
                                 char_code, last, range_error);
                        reported = reported + 1;
                    end
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (char_code !== want.code || last !== want.last
                        || range_error !== want.err)
                    begin
                        fail_count = fail_count + 1;
                        if (reported < 10)
                        begin
                            $display("mismatch: expected %h %b %b, got %h %b %b",
                                     want.code, want.last, want.err,
                                     char_code, last, range_error);
                            reported = reported + 1;
                        end
                    end
                end
            end
            if (push && !full)
                spell_numeral(value);
            pending_count = expected_chars.size();
        end
    end

endmodule

FILE: tb/roman_numeral_encoder_core_tb.sv
// Stimulus and verdict for the Roman numeral encoder core.
// Depends on roman_numeral_encoder_core and rne_numeral_checker.
module roman_numeral_encoder_core_tb;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic [11:0] value;
    logic        full;
    logic [7:0]  char_code;
    logic        last;
    logic        range_error;
    logic        empty;
    logic        pop;
    logic        popped;
    int          fail_count;
    int          pending_count;

    roman_numeral_encoder_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .value       (value),
        .full        (full),
        .char_code   (char_code),
        .last        (last),
        .range_error (range_error),
        .empty       (empty),
        .pop         (pop)
    );

    rne_numeral_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .value         (value),
        .empty         (empty),
        .pop           (pop),
        .char_code     (char_code),
        .last          (last),
        .range_error   (range_error),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        popped <= rst_n && pop && !empty;

    task automatic send_value(input logic [11:0] v, input int gap);
        if (gap > 0)
        begin
            push = 1'b0;
            value = 12'($urandom);
            repeat (gap) @(negedge clk);
        end
        value = v;
        push = 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        push = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    function automatic logic [11:0] random_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 12'($urandom_range(4000, 4095));
        else if (pick == 1)
            return 12'd0;
        else if (pick == 2)
            return 12'($urandom_range(3000, 3999));
        return 12'($urandom_range(1, 3999));
    endfunction

    initial
    begin
        int stall;
        bit burst;
        pop = 1'b0;
        stall = 0;
        burst = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (popped)
            begin
                if ($urandom_range(0, 47) == 0)
                    burst = !burst;
                stall = burst ? 0 : $urandom_range(0, 4);
            end
            if (stall > 0)
            begin
                pop = 1'b0;
                stall = stall - 1;
            end
            else
                pop = 1'b1;
        end
    end

    initial
    begin
        logic [11:0] directed[25];
        bit          burst;
        int          i;
        directed = '{12'd0, 12'd4095, 12'd4000, 12'd1, 12'd3999, 12'd3888, 12'd4,
                     12'd5, 12'd9, 12'd3, 12'd8, 12'd40, 12'd90, 12'd400, 12'd900,
                     12'd1000, 12'd2048, 12'd1234, 12'd1567, 12'd2789, 12'd3456,
                     12'd10, 12'd500, 12'd606, 12'd2730};
        rst_n = 1'b0;
        push = 1'b0;
        value = 12'd0;
        burst = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        for (i = 0; i < 25; i++)
            send_value(directed[i], $urandom_range(0, 4));
        drain_results();
        for (i = 0; i < 280; i++)
        begin
            if ($urandom_range(0, 31) == 0)
                burst = !burst;
            if (i == 140)
                drain_results();
            send_value(random_value(), burst ? 0 : $urandom_range(0, 4));
        end
        drain_results();
        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("roman_numeral_encoder_core verification clean");
        else
            $display("roman_numeral_encoder_core verification failed");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("roman_numeral_encoder_core verification failed");
        $finish;
    end

endmodule
